@@ design/metronome_click_generator_defines.svh @@
// assertion macros shared by the metronome click generator
`ifndef METRONOME_CLICK_GENERATOR_DEFINES_SVH
`define METRONOME_CLICK_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
// property checked on every rising edge outside reset
`define MCG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("metronome click generator check failed");
// property checked on every rising edge, reset included
`define MCG_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("metronome click generator check failed");
`else
`define MCG_ASSERT(label, clk, rst, prop)
`define MCG_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

@@ design/mcg_pkg.sv @@
`timescale 1ns / 1ps

package mcg_pkg;

   // default geometry
   localparam int CLIP_SAMPLES_DEFAULT    = 4800;
   localparam int PHASE_FRAC_BITS_DEFAULT = 16;

   // fixed field widths
   localparam int PHASE_W   = 34;
   localparam int BPB_W     = 5;
   localparam int BEAT_W    = 4;
   localparam int SAMPLE_W  = 16;
   localparam int CADDR_W   = 13;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 34;

   // reset values of the control registers
   localparam logic [PHASE_W-1:0] BEAT_PERIOD_RESET   = 34'd1572864000;
   localparam logic [BPB_W-1:0]   BEATS_PER_BAR_RESET = 5'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BEAT_PERIOD   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BEATS_PER_BAR = 1'b1;

   // request commands
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // clip selection
   localparam logic CLIP_NORMAL = 1'b0;
   localparam logic CLIP_ACCENT = 1'b1;

   // result queue depth
   localparam int QUEUE_DEPTH = 3;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 2;

   typedef struct packed {
      logic                       command;
      logic                       clip_choice;
      logic [CADDR_W-1:0]         clip_address;
      logic signed [SAMPLE_W-1:0] clip_value;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] audio_sample;
      logic [BEAT_W-1:0]          beat_number;
   } rsp_type;

   // what the beat tracker says about the current tick
   typedef struct packed {
      logic              in_window;
      logic              accent;
      logic [BEAT_W-1:0] beat;
   } tick_info_type;

endpackage

@@ design/mcg_clip_ram.sv @@
`timescale 1ns / 1ps

module mcg_clip_ram #(
   parameter int DEPTH  = 4800,
   parameter int ADDR_W = 13
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [mcg_pkg::SAMPLE_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic [mcg_pkg::SAMPLE_W-1:0] rd_data
);
   import mcg_pkg::*;

   logic [SAMPLE_W-1:0] clip_mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         clip_mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= clip_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/mcg_beat_track.sv @@
`timescale 1ns / 1ps
`include "metronome_click_generator_defines.svh"

module mcg_beat_track #(
   parameter int CLIP_SAMPLES    = mcg_pkg::CLIP_SAMPLES_DEFAULT,
   parameter int PHASE_FRAC_BITS = mcg_pkg::PHASE_FRAC_BITS_DEFAULT,
   parameter int ADDR_W          = 13
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [mcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcg_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           tick,
   output logic [ADDR_W-1:0]              rd_addr,
   output mcg_pkg::tick_info_type         info
);
   import mcg_pkg::*;

   localparam int WIN_W = PHASE_W + 24 - PHASE_FRAC_BITS + 17;
   localparam logic [WIN_W-1:0] WINDOW_END =
      WIN_W'(CLIP_SAMPLES) << PHASE_FRAC_BITS;
   localparam logic [PHASE_W-1:0] ONE_SAMPLE = PHASE_W'(1) << PHASE_FRAC_BITS;

   logic [PHASE_W-1:0] period_ff, period_in;
   logic [BPB_W-1:0]   bpb_ff, bpb_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BEAT_W-1:0]  count_ff, count_in;
   logic [PHASE_W-1:0] phase_step;
   logic [BPB_W-1:0]   count_plus;
   logic               count_wrap;

   // what the current state says about this tick
   always_comb begin
      info.in_window = WIN_W'(phase_ff) < WINDOW_END;
      info.accent    = (bpb_ff > BPB_W'(1)) && (count_ff == '0);
      info.beat      = count_ff;
      rd_addr        = ADDR_W'(phase_ff >> PHASE_FRAC_BITS);
   end

   // phase advance, beat wrap and register writes
   always_comb begin
      phase_step = phase_ff + ONE_SAMPLE;
      count_plus = {1'b0, count_ff} + BPB_W'(1);
      count_wrap = (count_plus >= bpb_ff) || (count_plus > BPB_W'(15));
      period_in  = period_ff;
      bpb_in     = bpb_ff;
      phase_in   = phase_ff;
      count_in   = count_ff;
      if (tick) begin
         if (phase_step > period_ff) begin
            phase_in = phase_step - period_ff;
            count_in = count_wrap ? '0 : count_plus[BEAT_W-1:0];
         end else begin
            phase_in = phase_step;
         end
      end
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BEAT_PERIOD: begin
               period_in = csr_wdata[PHASE_W-1:0];
            end
            CSR_BEATS_PER_BAR: begin
               bpb_in   = csr_wdata[BPB_W-1:0];
               count_in = '0;
            end
            default: begin
               period_in = period_ff;
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= BEAT_PERIOD_RESET;
         bpb_ff    <= BEATS_PER_BAR_RESET;
         phase_ff  <= '0;
         count_ff  <= '0;
      end else begin
         period_ff <= period_in;
         bpb_ff    <= bpb_in;
         phase_ff  <= phase_in;
         count_ff  <= count_in;
      end
   end

   // beat counter stays inside the bar
   `MCG_ASSERT(a_count_in_bar, clock, reset,
      (bpb_ff != '0 && bpb_ff <= BPB_W'(16)) |-> (BPB_W'(count_ff) < bpb_ff))
   // writing beats per bar restarts the bar
   `MCG_ASSERT(a_bpb_clears, clock, reset,
      (csr_wr_en && csr_index == CSR_BEATS_PER_BAR) |=> (count_ff == '0))
   // beat counter moves only on a tick or a register write
   `MCG_ASSERT(a_count_quiet, clock, reset,
      (!tick && !csr_wr_en) |=> $stable(count_ff))

endmodule

@@ design/mcg_out_queue.sv @@
`timescale 1ns / 1ps
`include "metronome_click_generator_defines.svh"

module mcg_out_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mcg_pkg::rsp_type push_data,
   output logic [mcg_pkg::QCNT_W-1:0] count,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mcg_pkg::rsp_type rsp_data
);
   import mcg_pkg::*;

   rsp_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // never written past full
   `MCG_ASSERT(a_no_overflow, clock, reset,
      !(push && !pop && count_ff == QCNT_W'(QUEUE_DEPTH)))
   // fill rises by one on a push without a pop
   `MCG_ASSERT(a_fill_tracks, clock, reset,
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
   // pointers are equal when the queue is empty
   `MCG_ASSERT(a_ptrs_match, clock, reset,
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))

endmodule

@@ design/metronome_click_generator.sv @@
`timescale 1ns / 1ps
`include "metronome_click_generator_defines.svh"

// metronome click generator: one audio sample per tick request
// req channel carries tick and clip write requests (req_valid, req_stall,
// req_data); a write stores one clip word and gives no result, a tick gives
// one rsp item (audio sample and beat number) on the rsp channel
// csr port: beat period (index 0, Q16 samples) and beats per bar (index 1);
// write it only while no request is in flight; beats per bar also restarts
// the bar at beat 0
// throughput: one request per cycle while req_stall is low; the phase add,
// compare and subtract and the clip read address are formed in the accept cycle
// a tick reads the clip memory at the edge that accepts it; its result goes
// through the read stage into the output queue, which drives rsp
// results sit in a three-entry queue; while rsp_stall is high the queue fills
// and req_stall rises once the queue plus the read stage hold three results
// reset clears phase, beat counter, queue and the pipeline valid; the clip
// memories keep their contents and must be loaded before playback
module metronome_click_generator #(
   parameter int CLIP_SAMPLES    = mcg_pkg::CLIP_SAMPLES_DEFAULT,
   parameter int PHASE_FRAC_BITS = mcg_pkg::PHASE_FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  mcg_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output mcg_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [mcg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mcg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mcg_pkg::*;

   localparam int ADDR_W = (CLIP_SAMPLES > 1) ? $clog2(CLIP_SAMPLES) : 1;
   localparam int CMP_W  = 18;

   logic                accept;
   logic                tick;
   logic                wr_ok;
   logic                wr_normal;
   logic                wr_accent;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   tick_info_type       info;
   logic                s1_valid_ff;
   tick_info_type       s1_info_ff;
   logic [SAMPLE_W-1:0] normal_data;
   logic [SAMPLE_W-1:0] accent_data;
   rsp_type             s1_rsp;
   logic [QCNT_W-1:0]   q_count;
   logic [QCNT_W:0]     in_flight;

   // accept while the queue has room for everything in flight
   assign in_flight = {1'b0, q_count} + (QCNT_W + 1)'(s1_valid_ff);
   assign req_stall = in_flight >= (QCNT_W + 1)'(QUEUE_DEPTH);
   assign accept    = req_valid && !req_stall;
   assign tick      = accept && (req_data.command == CMD_TICK);

   // clip write decode, out of range addresses are dropped
   assign wr_ok     = accept && (req_data.command == CMD_WRITE) &&
                      (CMP_W'(req_data.clip_address) < CMP_W'(CLIP_SAMPLES));
   assign wr_normal = wr_ok && (req_data.clip_choice == CLIP_NORMAL);
   assign wr_accent = wr_ok && (req_data.clip_choice == CLIP_ACCENT);
   assign wr_addr   = ADDR_W'(req_data.clip_address);

   mcg_beat_track #(
      .CLIP_SAMPLES    (CLIP_SAMPLES),
      .PHASE_FRAC_BITS (PHASE_FRAC_BITS),
      .ADDR_W          (ADDR_W)
   ) u_beat (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .tick      (tick),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   mcg_clip_ram #(
      .DEPTH  (CLIP_SAMPLES),
      .ADDR_W (ADDR_W)
   ) u_normal (
      .clock   (clock),
      .wr_en   (wr_normal),
      .wr_addr (wr_addr),
      .wr_data (req_data.clip_value),
      .rd_en   (tick),
      .rd_addr (rd_addr),
      .rd_data (normal_data)
   );

   mcg_clip_ram #(
      .DEPTH  (CLIP_SAMPLES),
      .ADDR_W (ADDR_W)
   ) u_accent (
      .clock   (clock),
      .wr_en   (wr_accent),
      .wr_addr (wr_addr),
      .wr_data (req_data.clip_value),
      .rd_en   (tick),
      .rd_addr (rd_addr),
      .rd_data (accent_data)
   );

   // read stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= tick;
      end
   end

   always_ff @(posedge clock) begin
      if (tick) begin
         s1_info_ff <= info;
      end
   end

   // pick the clip and silence outside the window
   always_comb begin
      s1_rsp.beat_number = s1_info_ff.beat;
      if (!s1_info_ff.in_window) begin
         s1_rsp.audio_sample = '0;
      end else if (s1_info_ff.accent) begin
         s1_rsp.audio_sample = accent_data;
      end else begin
         s1_rsp.audio_sample = normal_data;
      end
   end

   mcg_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s1_valid_ff),
      .push_data (s1_rsp),
      .count     (q_count),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // read stage only follows an accepted tick
   `MCG_ASSERT(a_s1_from_tick, clock, reset,
      s1_valid_ff |-> $past(tick))
   // nothing in flight beyond queue room
   `MCG_ASSERT(a_room, clock, reset,
      in_flight <= (QCNT_W + 1)'(QUEUE_DEPTH))
   // no request taken while stalled
   `MCG_ASSERT_ALWAYS(a_no_take_stalled, clock,
      !(req_stall && (tick || wr_ok)))

endmodule
